>>> rtl/bmt_pkg.sv
package bmt_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Beat field widths
  localparam int unsigned CMD_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned RES_W = 7;

  // Command codes; the unused code behaves as a count
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_COUNT  = 2'd2
  } bmt_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
  } bmt_req_t;

  typedef struct packed {
    logic [RES_W-1:0] result_count;
    logic             found;
    logic             full_error;
  } bmt_rsp_t;

  // Sequencer to entry memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } bmt_mem_req_t;

  // Sequencer to output register
  typedef struct packed {
    logic     valid;
    bmt_rsp_t rsp;
  } bmt_fin_t;

endpackage

>>> rtl/bmt_ram.sv
module bmt_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bmt_ctrl.sv
module bmt_ctrl
  import bmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bmt_req_t         req_i,
  output logic             busy_o,
  output bmt_mem_req_t     mem_o,
  input  logic [VAL_W-1:0] rdata_i,
  output bmt_fin_t         fin_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [CNT_W-1:0]   mcnt_q, mcnt_d;
  logic [CNT_W-1:0]   sh_q, sh_d;
  logic [VAL_W-1:0]   value_q, value_d;
  logic               rem_q, rem_d;

  logic               match;
  logic               issue;
  logic [CNT_W:0]     sh_next;

  // the one shared comparator: stored word against operand
  assign match   = pend_q && (rdata_i == value_q);
  assign issue   = idx_q < count_q;
  assign sh_next = {1'b0, sh_q} + (CNT_W+1)'(2);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    mcnt_d  = mcnt_q;
    sh_d    = sh_q;
    value_d = value_q;
    rem_d   = rem_q;
    mem_o   = '0;
    mem_o.wdata = value_q;
    mem_o.raddr = idx_q[ADDR_W-1:0];
    fin_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_i.cmd == CMD_INSERT) begin
            fin_o.valid = 1'b1;
            if (count_q == CNT_W'(CAPACITY)) begin
              fin_o.rsp.full_error   = 1'b1;
              fin_o.rsp.result_count = RES_W'(count_q);
            end else begin
              mem_o.we    = 1'b1;
              mem_o.waddr = count_q[ADDR_W-1:0];
              mem_o.wdata = req_i.value;
              count_d     = CNT_W'(count_q + 1'b1);
              fin_o.rsp.result_count = RES_W'(CNT_W'(count_q + 1'b1));
            end
          end else begin
            value_d = req_i.value;
            rem_d   = (req_i.cmd == CMD_REMOVE);
            idx_d   = '0;
            pend_d  = 1'b0;
            mcnt_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        pend_d = issue;
        if (issue) begin
          idx_d = CNT_W'(idx_q + 1'b1);
        end
        if (rem_q && match) begin
          // first hit at idx_q-1; the read of its successor is already out
          if (issue) begin
            sh_d    = CNT_W'(idx_q - 1'b1);
            state_d = ST_SHIFT;
          end else begin
            count_d = CNT_W'(count_q - 1'b1);
            fin_o.valid = 1'b1;
            fin_o.rsp.found        = 1'b1;
            fin_o.rsp.result_count = RES_W'(CNT_W'(count_q - 1'b1));
            state_d = ST_IDLE;
          end
        end else if (!issue) begin
          fin_o.valid = 1'b1;
          fin_o.rsp.result_count = rem_q ? RES_W'(count_q)
                                         : RES_W'(CNT_W'(mcnt_q + match));
          state_d = ST_IDLE;
        end else begin
          mcnt_d = CNT_W'(mcnt_q + match);
        end
      end

      ST_SHIFT: begin
        // move entry sh+1 down to sh, fetch sh+2 for the next beat
        mem_o.we    = 1'b1;
        mem_o.waddr = sh_q[ADDR_W-1:0];
        mem_o.wdata = rdata_i;
        mem_o.raddr = sh_next[ADDR_W-1:0];
        if (sh_next < {1'b0, count_q}) begin
          sh_d = CNT_W'(sh_q + 1'b1);
        end else begin
          count_d = CNT_W'(count_q - 1'b1);
          fin_o.valid = 1'b1;
          fin_o.rsp.found        = 1'b1;
          fin_o.rsp.result_count = RES_W'(CNT_W'(count_q - 1'b1));
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    mcnt_q  <= mcnt_d;
    sh_q    <= sh_d;
    value_q <= value_d;
    rem_q   <= rem_d;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> rtl/bounded_multiset_table_top.sv
// Multiset of up to CAPACITY (64) signed 32-bit words in insertion order.
// A command beat is taken when start is high and busy is low; exactly one
// result beat follows on rsp_o, marked by done_o for a single cycle, and it
// must be captured then: the receiver has no way to stall it. Insert does not
// raise busy and its result shows on the next cycle. Count keeps busy high
// while one comparator walks the entry memory one word per cycle through its
// registered read port. Remove scans up to the first match at position j
// and then moves the tail down one word per cycle, keeping busy high meanwhile.
// The result of a scan shows on done_o in the same cycle that busy falls,
// and a new command may be started in that same cycle. A full table refuses
// an insert with full_error set and the count unchanged; a remove that
// misses leaves the table as it was with found clear. Command code three
// acts as count. No clearing pass is needed after reset: only data read
// from slots below the fill count is ever used.
module bounded_multiset_table_top
  import bmt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  bmt_req_t req_i,
  output logic     done_o,
  output bmt_rsp_t rsp_o
);

  bmt_mem_req_t     mem_req;
  logic [VAL_W-1:0] mem_rdata;
  bmt_fin_t         fin;

  logic             done_q;
  bmt_rsp_t         rsp_q;

  // Sequencer: fill count, scan/shift pointers and the shared comparator
  bmt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .busy_o  (busy),
    .mem_o   (mem_req),
    .rdata_i (mem_rdata),
    .fin_o   (fin)
  );

  // Entry store: one write and one registered read per cycle
  bmt_ram #(
    .Depth (CAPACITY),
    .Width (VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Result register: the beat is shown for exactly one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin.valid) begin
      rsp_q <= fin.rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> rtl/bmt_chk.sv
module bmt_chk
  import bmt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input bmt_req_t req_i,
  input logic     done_i,
  input bmt_rsp_t rsp_i
);

  // a result beat never overlaps a running scan
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy)
    else $error("result beat while busy");

  // insert answers on the very next cycle
  a_insert_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd == CMD_INSERT)) |=> done_i)
    else $error("insert result missing");

  // busy only rises from an accepted command
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without a command");

  // refusal only at the full mark and never together with a hit
  a_full_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && rsp_i.full_error) |->
      (!rsp_i.found && (rsp_i.result_count == RES_W'(CAPACITY))))
    else $error("inconsistent full flag");

endmodule

bind bounded_multiset_table_top bmt_chk u_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_i (done_o),
  .rsp_i  (rsp_o)
);
